### rtl/core/plgt_pkg.sv
// Package with shared types, constants and lookup tables for the pixel point transform.
`default_nettype none
package plgt_pkg;

   localparam int SEARCH_BITS = 8;
   localparam int LANE_DEPTH  = SEARCH_BITS + 2;
   localparam int TAB_W       = 27;
   localparam int FRAC_BITS   = 24;
   localparam int MANT_BITS   = 30;
   localparam logic [63:0] LN2_Q30 = 64'd744261118;

   typedef enum logic [1:0] {
      CSR_MODE      = 2'd0,
      CSR_LOG_GAIN  = 2'd1,
      CSR_GAMMA_EXP = 2'd2
   } csr_index_type;

   typedef logic [TAB_W-1:0] tab_type [256];

   typedef struct packed {
      logic        adv;
      logic        mode;
      logic [7:0]  gain;
      logic [15:0] gexp;
   } plgt_ctl_type;

   // Base-2 log of x in Q24 by repeated squaring of a Q30 mantissa.
   function automatic logic [27:0] log2_q24(input int x);
      int          xv;
      int          n;
      logic [63:0] m;
      logic [27:0] frac;
      xv   = (x < 1) ? 1 : x;
      n    = 0;
      frac = '0;
      while (n < 8 && (xv >> (n + 1)) != 0) n++;
      m = 64'(xv) << (MANT_BITS - n);
      for (int i = 0; i < FRAC_BITS; i++) begin
         m    = (m * m) >> MANT_BITS;
         frac = frac << 1;
         if (m >= (64'd2 << MANT_BITS)) begin
            m    = m >> 1;
            frac = frac | 28'd1;
         end
      end
      return (28'(n) << FRAC_BITS) | frac;
   endfunction

   // Natural log of p + 1 in Q24, indexed by p.
   function automatic tab_type build_ln();
      tab_type     t;
      logic [63:0] v;
      for (int p = 0; p < 256; p++) begin
         v    = (64'(log2_q24(p + 1)) * LN2_Q30) >> MANT_BITS;
         t[p] = TAB_W'(v);
      end
      return t;
   endfunction

   // Log distance from full scale, log2(255) - log2(v), in Q24.
   function automatic tab_type build_dist();
      tab_type t;
      for (int v = 0; v < 256; v++) begin
         t[v] = TAB_W'(log2_q24(255) - log2_q24(v));
      end
      return t;
   endfunction

   localparam tab_type LN_TAB   = build_ln();
   localparam tab_type DIST_TAB = build_dist();

endpackage
`default_nettype wire

### rtl/core/plgt_if.sv
// Request and response channel interfaces of the pixel point transform.
`default_nettype none
interface plgt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_in;
   logic [7:0] green_in;
   logic [7:0] blue_in;
   logic       frame_end_in;
   modport source (output valid, red_in, green_in, blue_in, frame_end_in, input ready);
   modport sink   (input valid, red_in, green_in, blue_in, frame_end_in, output ready);
endinterface

interface plgt_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_out;
   logic [7:0] green_out;
   logic [7:0] blue_out;
   logic       frame_end_out;
   modport source (output valid, red_out, green_out, blue_out, frame_end_out, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, frame_end_out, output ready);
endinterface
`default_nettype wire

### rtl/core/plgt_lane.sv
// One channel lane: table lookup, multiply, then a pipelined bitwise gamma search.
`default_nettype none
module plgt_lane (
   input  wire                  clock,
   input  plgt_pkg::plgt_ctl_type ctl,
   input  wire  [7:0]           pix_in,
   output logic [7:0]           pix_out
);
   import plgt_pkg::*;

   logic [7:0]  p_ff;
   logic [42:0] tgt_ff  [SEARCH_BITS+1];
   logic [7:0]  ans_ff  [SEARCH_BITS+1];
   logic [34:0] lp_ff   [SEARCH_BITS+1];
   logic        zero_ff [SEARCH_BITS+1];

   always_ff @(posedge clock) begin
      if (ctl.adv) begin
         p_ff       <= pix_in;
         tgt_ff[0]  <= 43'(ctl.gexp) * 43'(DIST_TAB[p_ff]);
         lp_ff[0]   <= 35'(ctl.gain) * 35'(LN_TAB[p_ff]);
         zero_ff[0] <= (p_ff == 8'd0);
         ans_ff[0]  <= 8'd0;
      end
   end

   // One result bit per stage, from the top bit down.
   for (genvar k = 0; k < SEARCH_BITS; k++) begin : g_search
      logic [7:0] cand;
      logic       take;
      assign cand = ans_ff[k] | (8'd1 << (SEARCH_BITS - 1 - k));
      assign take = {4'b0, DIST_TAB[cand], 12'b0} >= tgt_ff[k];
      always_ff @(posedge clock) begin
         if (ctl.adv) begin
            tgt_ff[k+1]  <= tgt_ff[k];
            lp_ff[k+1]   <= lp_ff[k];
            zero_ff[k+1] <= zero_ff[k];
            ans_ff[k+1]  <= take ? cand : ans_ff[k];
         end
      end
   end

   logic [10:0] log_val;
   assign log_val = lp_ff[SEARCH_BITS][34:24];

   always_comb begin
      if (ctl.mode) begin
         if (ctl.gexp == 16'd0)          pix_out = 8'd255;
         else if (zero_ff[SEARCH_BITS])  pix_out = 8'd0;
         else                            pix_out = ans_ff[SEARCH_BITS];
      end else begin
         pix_out = (log_val > 11'd255) ? 8'd255 : log_val[7:0];
      end
   end
endmodule
`default_nettype wire

### rtl/core/pixel_log_gamma_point_transform.sv
// Top level of the per-pixel log and gamma point transform.
// The block maps each color channel of an RGB pixel through a log curve or a gamma curve,
// selected by the mode register. Requests arrive on the req channel (valid/ready) with
// three 8-bit channels and a frame-end flag; results leave on the rsp channel.
// Configuration is written through csr_write_en, csr_index and csr_wdata: index 0 is the
// mode (0 log, 1 gamma), index 1 the log gain, index 2 the Q4.12 gamma exponent.
// Write registers only while no request is in flight.
// Three identical lanes process red, green and blue side by side; the output register
// merges the lanes with the frame-end flag into one response.
// The request lands in the input register at the accepting edge, then passes one table
// lookup and multiply stage, eight binary search stages (one result bit each), and the
// output register. Throughput is one pixel per clock.
// When the receiver stalls, the whole pipeline holds and ready drops; while the output
// register is empty the pipeline keeps moving.
// A synchronous reset empties the pipeline and restores mode 1, gain 46 and exponent 1.0.
`default_nettype none
module pixel_log_gamma_point_transform (
   input  wire         clock,
   input  wire         reset,
   plgt_req_if.sink    req,
   plgt_rsp_if.source  rsp,
   input  wire         csr_write_en,
   input  wire  [1:0]  csr_index,
   input  wire  [15:0] csr_wdata
);
   import plgt_pkg::*;

   logic        mode_ff;
   logic [7:0]  gain_ff;
   logic [15:0] gexp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b1;
         gain_ff <= 8'd46;
         gexp_ff <= 16'd4096;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_MODE:      mode_ff <= csr_wdata[0];
            CSR_LOG_GAIN:  gain_ff <= csr_wdata[7:0];
            CSR_GAMMA_EXP: gexp_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The pipeline advances whenever the output register can take a new value.
   logic         adv;
   plgt_ctl_type ctl;
   assign adv       = !rsp.valid || rsp.ready;
   assign req.ready = adv;
   assign ctl       = '{adv: adv, mode: mode_ff, gain: gain_ff, gexp: gexp_ff};

   logic [LANE_DEPTH-1:0] vld_ff;
   logic [LANE_DEPTH-1:0] fe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LANE_DEPTH-2:0], req.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fe_ff <= {fe_ff[LANE_DEPTH-2:0], req.frame_end_in};
      end
   end

   logic [7:0] red_res;
   logic [7:0] green_res;
   logic [7:0] blue_res;

   plgt_lane u_red   (.clock(clock), .ctl(ctl), .pix_in(req.red_in),   .pix_out(red_res));
   plgt_lane u_green (.clock(clock), .ctl(ctl), .pix_in(req.green_in), .pix_out(green_res));
   plgt_lane u_blue  (.clock(clock), .ctl(ctl), .pix_in(req.blue_in),  .pix_out(blue_res));

   // Output register: merges the three lanes and the frame-end flag.
   logic       rsp_valid_ff;
   logic [7:0] red_ff;
   logic [7:0] green_ff;
   logic [7:0] blue_ff;
   logic       fe_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vld_ff[LANE_DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         red_ff    <= red_res;
         green_ff  <= green_res;
         blue_ff   <= blue_res;
         fe_out_ff <= fe_ff[LANE_DEPTH-1];
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.red_out       = red_ff;
   assign rsp.green_out     = green_ff;
   assign rsp.blue_out      = blue_ff;
   assign rsp.frame_end_out = fe_out_ff;

   // Nothing is presented right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp.valid)
      else $error("response valid right after reset");

   // A taken response with no request in the last stage leaves the output empty.
   a_drain: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready && !vld_ff[LANE_DEPTH-1] |=> !rsp.valid)
      else $error("response appeared without a request behind it");
endmodule
`default_nettype wire
